[sv/ytr_pkg.sv]
// ----------------------------------------------------------------------------
// ytr_pkg
// Shared constants, types and coefficients of the YUYV to RGB565 writer.
// ----------------------------------------------------------------------------
package ytr_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int FRACTION_BITS = 14;

  localparam int SAMPLE_W  = 8;
  localparam int PIXEL_W   = 16;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = $clog2(MAX_DIMENSION) + 1;
  localparam int CNT_W     = $clog2(MAX_DIMENSION);
  localparam int POS_W     = DIM_W + 2;
  localparam int ACC_W     = FRACTION_BITS + 11;
  localparam int COEF_W    = FRACTION_BITS + 2;

  // Coefficients scaled by 2^FRACTION_BITS, rounded to nearest
  localparam longint ONE_Q = longint'(1) << FRACTION_BITS;
  localparam longint COEF_RV_Q = (1402 * ONE_Q + 500) / 1000;
  localparam longint COEF_GU_Q = (344136 * ONE_Q + 500000) / 1000000;
  localparam longint COEF_GV_Q = (714136 * ONE_Q + 500000) / 1000000;
  localparam longint COEF_BU_Q = (1772 * ONE_Q + 500) / 1000;

  localparam logic signed [COEF_W-1:0] COEF_RV = COEF_W'(COEF_RV_Q);
  localparam logic signed [COEF_W-1:0] COEF_GU = COEF_W'(COEF_GU_Q);
  localparam logic signed [COEF_W-1:0] COEF_GV = COEF_W'(COEF_GV_Q);
  localparam logic signed [COEF_W-1:0] COEF_BU = COEF_W'(COEF_BU_Q);

  localparam logic [SAMPLE_W:0] CHROMA_OFFSET = (SAMPLE_W + 1)'(128);

  localparam logic [DIM_W-1:0] RESET_SCREEN_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_SCREEN_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH   = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT  = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } cfg_reg_t;

endpackage

[sv/ytr_pair_if.sv]
// ----------------------------------------------------------------------------
// ytr_pair_if
// Input channel: one YUYV macropixel per transfer.
// ----------------------------------------------------------------------------
interface ytr_pair_if import ytr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_first;
  logic [SAMPLE_W-1:0] chroma_blue;
  logic [SAMPLE_W-1:0] luma_second;
  logic [SAMPLE_W-1:0] chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                output ready);
endinterface

[sv/ytr_pixel_if.sv]
// ----------------------------------------------------------------------------
// ytr_pixel_if
// Output channel: two RGB565 pixels and their framebuffer placement.
// ----------------------------------------------------------------------------
interface ytr_pixel_if import ytr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_first;
  logic [PIXEL_W-1:0] pixel_second;
  logic [IDX_W-1:0]   pixel_index;
  logic               off_screen;
  logic               frame_end;

  modport source (output valid, pixel_first, pixel_second, pixel_index, off_screen,
                  frame_end, input ready);
  modport sink (input valid, pixel_first, pixel_second, pixel_index, off_screen,
                frame_end, output ready);
endinterface

[sv/yuyv_to_rgb565_framebuffer_writer_unit.sv]
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_framebuffer_writer_unit
// YUYV macropixel to RGB565 converter with framebuffer placement.
//
// The pair channel takes one macropixel (Y0, U, Y1, V) per transfer. The
// pixel channel returns both pixels in RGB565, the framebuffer index of the
// first pixel with the image centred on the screen, an off-screen flag and a
// frame-end flag on the last pair of the frame. One result per pair.
// A pair passes an input stage (placement) and a result register (color
// math, index multiply). Throughput is one pair per cycle while the receiver
// does not stall; the color path is at most two constant multiplies and three
// adds or subtracts per channel between registers.
// The configuration port writes screen and image sizes, clamped on write;
// write only while no pair is in flight.
// Reset restores 640x480 screen and image and clears the column and row
// counters. When the receiver stalls, the result register holds and the
// input stage fills; the pair channel then drops ready until space frees.
// ----------------------------------------------------------------------------
module yuyv_to_rgb565_framebuffer_writer_unit import ytr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ytr_pair_if.sink             pair,
  ytr_pixel_if.source          pixel,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (DIM_W'(v) > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-FRACTION_BITS-1:0] q;
    logic [SAMPLE_W-1:0]            r;
    q = acc[ACC_W-1:FRACTION_BITS];
    if (acc[ACC_W-1]) begin
      r = '0;
    end else if (q > (ACC_W-FRACTION_BITS)'(255)) begin
      r = '1;
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PIXEL_W-1:0] pack565(
    input logic [SAMPLE_W-1:0]     y,
    input logic signed [ACC_W-1:0] pr,
    input logic signed [ACC_W-1:0] pg,
    input logic signed [ACC_W-1:0] pb
  );
    logic signed [ACC_W-1:0] base;
    logic [SAMPLE_W-1:0]     r;
    logic [SAMPLE_W-1:0]     g;
    logic [SAMPLE_W-1:0]     b;
    base = ACC_W'(signed'({1'b0, y})) <<< FRACTION_BITS;
    r = to_byte(base + pr);
    g = to_byte(base - pg);
    b = to_byte(base + pb);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Configuration, stored already clamped
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] cfg_dim;
  logic [DIM_W-1:0] cfg_iw;

  always_comb begin
    cfg_dim = clamp_dim(cfg_data);
    cfg_iw  = cfg_dim;
    if (cfg_iw < DIM_W'(2)) begin
      cfg_iw = DIM_W'(2);
    end
    cfg_iw[0] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_SCREEN_WIDTH;
      screen_height <= RESET_SCREEN_HEIGHT;
      image_width   <= RESET_IMAGE_WIDTH;
      image_height  <= RESET_IMAGE_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_dim;
        REG_SCREEN_HEIGHT: screen_height <= cfg_dim;
        REG_IMAGE_WIDTH:   image_width   <= cfg_iw;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_dim;
        default: ;
      endcase
    end
  end

  // Handshake
  logic a_valid;
  logic out_valid;
  logic out_take;
  logic a_adv;
  logic accept;

  assign out_take   = !out_valid || pixel.ready;
  assign a_adv      = a_valid && out_take;
  assign pair.ready = !a_valid || out_take;
  assign accept     = pair.valid && pair.ready;

  // Position counters
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic             row_last;
  logic             frame_last;

  assign row_last   = (DIM_W'(column_count) + DIM_W'(2)) >= image_width;
  assign frame_last = row_last && ((DIM_W'(row_count) + DIM_W'(1)) >= image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_last) begin
        column_count <= '0;
        row_count    <= frame_last ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(2);
      end
    end
  end

  // Centring offsets, truncated toward zero
  logic signed [DIM_W:0]   xdiff;
  logic signed [DIM_W:0]   ydiff;
  logic signed [DIM_W:0]   xoff;
  logic signed [DIM_W:0]   yoff;
  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;

  always_comb begin
    xdiff = signed'({1'b0, screen_width}) - signed'({1'b0, image_width});
    ydiff = signed'({1'b0, screen_height}) - signed'({1'b0, image_height});
    xoff  = (xdiff + signed'({{DIM_W{1'b0}}, xdiff[DIM_W]})) >>> 1;
    yoff  = (ydiff + signed'({{DIM_W{1'b0}}, ydiff[DIM_W]})) >>> 1;
    sx    = POS_W'(signed'({1'b0, column_count})) + POS_W'(xoff);
    sy    = POS_W'(signed'({1'b0, row_count})) + POS_W'(yoff);
  end

  // Input stage
  logic [SAMPLE_W-1:0]     a_y0;
  logic [SAMPLE_W-1:0]     a_u;
  logic [SAMPLE_W-1:0]     a_y1;
  logic [SAMPLE_W-1:0]     a_v;
  logic signed [POS_W-1:0] a_sx;
  logic signed [POS_W-1:0] a_sy;
  logic                    a_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_y0        <= pair.luma_first;
      a_u         <= pair.chroma_blue;
      a_y1        <= pair.luma_second;
      a_v         <= pair.chroma_red;
      a_sx        <= sx;
      a_sy        <= sy;
      a_frame_end <= frame_last;
    end
  end

  // Color and placement
  logic signed [SAMPLE_W:0]  du;
  logic signed [SAMPLE_W:0]  dv;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   prod_g;
  logic signed [ACC_W-1:0]   prod_b;
  logic                      off;
  logic [2*DIM_W-1:0]        idx_full;
  logic [PIXEL_W-1:0]        pix0;
  logic [PIXEL_W-1:0]        pix1;
  logic [IDX_W-1:0]          idx;

  always_comb begin
    du     = signed'({1'b0, a_u}) - signed'(CHROMA_OFFSET);
    dv     = signed'({1'b0, a_v}) - signed'(CHROMA_OFFSET);
    prod_r = ACC_W'(COEF_RV) * ACC_W'(dv);
    prod_g = ACC_W'(COEF_GU) * ACC_W'(du) + ACC_W'(COEF_GV) * ACC_W'(dv);
    prod_b = ACC_W'(COEF_BU) * ACC_W'(du);
    pix0   = pack565(a_y0, prod_r, prod_g, prod_b);
    pix1   = pack565(a_y1, prod_r, prod_g, prod_b);

    off = a_sx[POS_W-1] || a_sy[POS_W-1]
       || ((a_sx + POS_W'(1)) >= signed'(POS_W'(screen_width)))
       || (a_sy >= signed'(POS_W'(screen_height)));
    idx_full = (2*DIM_W)'(a_sy[DIM_W-1:0]) * (2*DIM_W)'(screen_width)
             + (2*DIM_W)'(a_sx[DIM_W-1:0]);
    idx = off ? '0 : IDX_W'(idx_full);
  end

  // Result register
  logic [PIXEL_W-1:0] out_pixel_first;
  logic [PIXEL_W-1:0] out_pixel_second;
  logic [IDX_W-1:0]   out_pixel_index;
  logic               out_off_screen;
  logic               out_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_pixel_first  <= pix0;
      out_pixel_second <= pix1;
      out_pixel_index  <= idx;
      out_off_screen   <= off;
      out_frame_end    <= a_frame_end;
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.pixel_first  = out_pixel_first;
  assign pixel.pixel_second = out_pixel_second;
  assign pixel.pixel_index  = out_pixel_index;
  assign pixel.off_screen   = out_off_screen;
  assign pixel.frame_end    = out_frame_end;

  // Checks
  a_off_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_off_screen |-> out_pixel_index == '0)
    else $error("off-screen pair carries a nonzero index");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> column_count == '0 && row_count == '0)
    else $error("counters did not restart after the last pair of a frame");

  a_column_step: assert property (@(posedge clk) disable iff (rst)
    accept && !row_last |=> column_count == $past(column_count) + CNT_W'(2))
    else $error("column counter did not advance by one pair");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !out_take |=> a_valid && $stable(a_sx) && $stable(a_sy))
    else $error("input stage lost its pair while the output was stalled");

endmodule
